[hw/rtl/sfh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sfh_pkg;

    localparam int HASH_W = 32;
    localparam int BYTE_W = 8;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Group size codes: a full group of four bytes wraps to zero.
    localparam logic [1:0] GRP_FULL  = 2'd0;
    localparam logic [1:0] GRP_ONE   = 2'd1;
    localparam logic [1:0] GRP_TWO   = 2'd2;
    localparam logic [1:0] GRP_THREE = 2'd3;

    typedef struct packed {
        logic [HASH_W-1:0] data;   // bytes of the group, first byte in the low bits
        logic [1:0]        cnt;    // GRP_FULL or the number of leftover bytes
        logic              last;   // group closes the message
        logic              first;  // group opens the message
    } qitem_t;

    function automatic logic [HASH_W-1:0] sext8(input logic [BYTE_W-1:0] b);
        sext8 = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    function automatic logic [HASH_W-1:0] main_round(input logic [HASH_W-1:0] h,
                                                      input logic [HASH_W-1:0] d);
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] hi;
        logic [HASH_W-1:0] h2;
        h1 = h + {16'd0, d[15:0]};
        hi = {16'd0, d[31:16]};
        h2 = (h1 << 16) ^ (hi << 11) ^ h1;
        main_round = h2 + (h2 >> 11);
    endfunction

    function automatic logic [HASH_W-1:0] mix_group(input logic [HASH_W-1:0] h,
                                                     input qitem_t item);
        logic [HASH_W-1:0] t;
        t = h;
        case (item.cnt)
            GRP_FULL:
            begin
                t = main_round(h, item.data);
            end
            GRP_THREE:
            begin
                t = h + {16'd0, item.data[15:0]};
                t = t ^ (t << 16);
                t = t ^ (sext8(item.data[23:16]) << 18);
                t = t + (t >> 11);
            end
            GRP_TWO:
            begin
                t = h + {16'd0, item.data[15:0]};
                t = t ^ (t << 11);
                t = t + (t >> 17);
            end
            GRP_ONE:
            begin
                t = h + sext8(item.data[7:0]);
                t = t ^ (t << 10);
                t = t + (t >> 1);
            end
            default:
            begin
                t = h;
            end
        endcase
        mix_group = t;
    endfunction

    function automatic logic [HASH_W-1:0] aval_a(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h ^ (h << 3);
        aval_a = t + (t >> 5);
    endfunction

    function automatic logic [HASH_W-1:0] aval_b(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h ^ (h << 4);
        aval_b = t + (t >> 17);
    endfunction

    function automatic logic [HASH_W-1:0] aval_c(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h ^ (h << 25);
        aval_c = t + (t >> 6);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/sfh_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfh_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [sfh_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                        last,
    input  wire logic                        q_full,
    output logic                             push,
    output sfh_pkg::qitem_t                  push_item
);

    logic [1:0]                      cnt_reg;
    logic [1:0]                      cnt_next;
    logic [3*sfh_pkg::BYTE_W-1:0]    pend_reg;
    logic [3*sfh_pkg::BYTE_W-1:0]    pend_next;
    logic                            first_reg;
    logic                            first_next;
    logic                            accept;
    logic [sfh_pkg::HASH_W-1:0]      word;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Drop the new byte into its lane of the group.
    always_comb
    begin
        word = {8'd0, pend_reg};
        case (cnt_reg)
            2'd0:    word[7:0]   = data_byte;
            2'd1:    word[15:8]  = data_byte;
            2'd2:    word[23:16] = data_byte;
            2'd3:    word[31:24] = data_byte;
            default: word = {8'd0, pend_reg};
        endcase
    end

    assign push = accept && ((cnt_reg == 2'd3) || last);

    always_comb
    begin
        push_item.data  = word;
        push_item.cnt   = cnt_reg + 2'd1;
        push_item.last  = last;
        push_item.first = first_reg;
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        first_next = first_reg;
        if (push)
        begin
            cnt_next   = 2'd0;
            first_next = last;
        end
        else if (accept)
        begin
            cnt_next  = cnt_reg + 2'd1;
            pend_next = word[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 2'd0;
            first_reg <= 1'b1;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

[hw/rtl/sfh_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfh_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire sfh_pkg::qitem_t  push_item,
    input  wire logic             pop,
    output sfh_pkg::qitem_t       head,
    output logic                  full,
    output logic                  empty
);

    sfh_pkg::qitem_t                 mem_reg [sfh_pkg::QDEPTH];
    logic [sfh_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [sfh_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [sfh_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [sfh_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [sfh_pkg::QCNT_W-1:0]      count_reg;
    logic [sfh_pkg::QCNT_W-1:0]      count_next;

    assign full  = (count_reg == sfh_pkg::QCNT_W'(sfh_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + sfh_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + sfh_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + sfh_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - sfh_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sfh_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfh_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [sfh_pkg::HASH_W-1:0]  seed,
    input  wire sfh_pkg::qitem_t             head,
    input  wire logic                        q_empty,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [sfh_pkg::HASH_W-1:0]       out_hash
);

    logic                         adv;
    logic [sfh_pkg::HASH_W-1:0]   h_in;
    logic [sfh_pkg::HASH_W-1:0]   mixed;

    logic [sfh_pkg::HASH_W-1:0]   hash_reg;
    logic [sfh_pkg::HASH_W-1:0]   hash_next;
    logic                         v0_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         vout_reg;
    logic [sfh_pkg::HASH_W-1:0]   h0_reg;
    logic [sfh_pkg::HASH_W-1:0]   h1_reg;
    logic [sfh_pkg::HASH_W-1:0]   h2_reg;
    logic [sfh_pkg::HASH_W-1:0]   hout_reg;

    // The whole back end moves as one; hold everything while the result waits.
    assign adv   = !vout_reg || out_ready;
    assign pop   = adv && !q_empty;
    assign h_in  = head.first ? seed : hash_reg;
    assign mixed = sfh_pkg::mix_group(h_in, head);

    always_comb
    begin
        hash_next = hash_reg;
        if (pop && !head.last)
        begin
            hash_next = mixed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            if (adv)
            begin
                v0_reg   <= pop && head.last;
                v1_reg   <= v0_reg;
                v2_reg   <= v1_reg;
                vout_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h0_reg   <= mixed;
            h1_reg   <= sfh_pkg::aval_a(h0_reg);
            h2_reg   <= sfh_pkg::aval_b(h1_reg);
            hout_reg <= sfh_pkg::aval_c(h2_reg);
        end
    end

    assign out_valid = vout_reg;
    assign out_hash  = hout_reg;

endmodule

`default_nettype wire

[hw/rtl/superfast_byte_stream_hash_core.sv]
// Throughput: one byte per cycle, including back-to-back messages, while the output is not stalled.
// Path: the group holding the last byte passes through the four-entry group queue, then one
// group-mix stage and the avalanche stages, the last of which is the output register.
// Output backpressure stalls the back end; the group queue absorbs up to four groups.
// Reset: rst_n is asynchronous, active low; clears seed, queue and pipeline state.
`timescale 1ns / 1ps
`default_nettype none

module superfast_byte_stream_hash_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [sfh_pkg::HASH_W-1:0]  cfg_data,       // seed
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  wire logic                        s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [sfh_pkg::HASH_W-1:0]       m_axis_tdata    // [31:0] hash_value
);

    logic [sfh_pkg::HASH_W-1:0]   seed_reg;
    logic                         push;
    sfh_pkg::qitem_t              push_item;
    sfh_pkg::qitem_t              head;
    logic                         pop;
    logic                         q_full;
    logic                         q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    sfh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .data_byte (s_axis_tdata),
        .last      (s_axis_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    sfh_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    sfh_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[hw/rtl/sfh_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfh_checker
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tready,
    input  wire logic                        s_axis_tlast,
    input  wire logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic [sfh_pkg::HASH_W-1:0]  m_axis_tdata
);

    // Messages closed on the input side whose hash has not been taken yet.
    logic [3:0] open_reg;
    logic [3:0] open_next;
    logic       msg_in;
    logic       msg_out;

    assign msg_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign msg_out = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        open_next = open_reg;
        if (msg_in && !msg_out)
        begin
            open_next = open_reg + 4'd1;
        end
        else if (msg_out && !msg_in)
        begin
            open_next = open_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> open_reg != 4'd0)
        else $error("result word without a finished message");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= 4'd8)
        else $error("more messages in flight than the queue and pipeline hold");

    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the output side was moving");

endmodule

bind superfast_byte_stream_hash_core sfh_checker u_sfh_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[verif/sfh_hash_monitor.sv]
`timescale 1ns / 1ps

module sfh_hash_monitor
    import sfh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [HASH_W-1:0] cfg_data,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,
    input  wire logic              s_axis_tlast,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [HASH_W-1:0] m_axis_tdata,
    output int                     error_count,
    output int                     hashes_waiting
);

    logic [HASH_W-1:0] seed_q;
    logic [HASH_W-1:0] run_hash;
    logic [23:0]       held_bytes;
    logic [1:0]        held_cnt;
    logic              in_msg;
    logic [HASH_W-1:0] hash_fifo[$];

    initial
    begin
        error_count    = 0;
        hashes_waiting = 0;
    end

    function automatic logic [HASH_W-1:0] sign_byte(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [HASH_W-1:0] final_mix(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] t;
        t = h;
        t = t ^ (t << 3);
        t = t + (t >> 5);
        t = t ^ (t << 4);
        t = t + (t >> 17);
        t = t ^ (t << 25);
        t = t + (t >> 6);
        return t;
    endfunction

    // Fold the 1 to 3 leftover bytes of a message into the hash.
    function automatic logic [HASH_W-1:0] tail_fold(input logic [HASH_W-1:0] h,
                                                    input logic [23:0]       bytes,
                                                    input logic [1:0]        cnt);
        logic [HASH_W-1:0] t;
        t = h;
        case (cnt)
            GRP_THREE:
            begin
                t = t + {16'd0, bytes[15:0]};
                t = t ^ (t << 16);
                t = t ^ (sign_byte(bytes[23:16]) << 18);
                t = t + (t >> 11);
            end
            GRP_TWO:
            begin
                t = t + {16'd0, bytes[15:0]};
                t = t ^ (t << 11);
                t = t + (t >> 17);
            end
            GRP_ONE:
            begin
                t = t + sign_byte(bytes[7:0]);
                t = t ^ (t << 10);
                t = t + (t >> 1);
            end
            default:
            begin
                t = h;
            end
        endcase
        return t;
    endfunction

    task report_mismatch(input string what, input logic [HASH_W-1:0] got,
                         input logic [HASH_W-1:0] want);
        $display("ERROR at %0t ns: %s: got %08h, expected %08h", $time, what, got, want);
        error_count++;
    endtask

    task absorb_byte(input logic [7:0] b, input logic fin);
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] hi16;
        if (!in_msg)
        begin
            run_hash   = seed_q;
            held_bytes = '0;
            held_cnt   = GRP_FULL;
        end
        if (held_cnt == GRP_THREE)
        begin
            // Fourth byte completes the group: run the main round.
            h    = run_hash + {16'd0, held_bytes[15:0]};
            hi16 = {16'd0, b, held_bytes[23:16]};
            h    = (h << 16) ^ (hi16 << 11) ^ h;
            h    = h + (h >> 11);
            run_hash   = h;
            held_bytes = '0;
            held_cnt   = GRP_FULL;
        end
        else
        begin
            case (held_cnt)
                GRP_FULL: held_bytes[7:0]   = b;
                GRP_ONE:  held_bytes[15:8]  = b;
                default:  held_bytes[23:16] = b;
            endcase
            held_cnt = held_cnt + 2'd1;
        end
        if (fin)
        begin
            h = final_mix(tail_fold(run_hash, held_bytes, held_cnt));
            hash_fifo.push_back(h);
            run_hash   = h;
            held_bytes = '0;
            held_cnt   = GRP_FULL;
            in_msg     = 1'b0;
        end
        else
        begin
            in_msg = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [HASH_W-1:0] want;
        if (!rst_n)
        begin
            seed_q     = '0;
            run_hash   = '0;
            held_bytes = '0;
            held_cnt   = GRP_FULL;
            in_msg     = 1'b0;
            hash_fifo.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seed_q = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (hash_fifo.size() == 0)
                begin
                    report_mismatch("hash with no message pending", m_axis_tdata, '0);
                end
                else
                begin
                    want = hash_fifo.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch("hash_value", m_axis_tdata, want);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata, s_axis_tlast);
        end
        hashes_waiting = hash_fifo.size();
    end

endmodule

[verif/tb_superfast_byte_stream_hash_core.sv]
`timescale 1ns / 1ps

module tb_superfast_byte_stream_hash_core;

    import sfh_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 290;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [HASH_W-1:0] cfg_data      = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [HASH_W-1:0] m_axis_tdata;

    int          error_count;
    int          hashes_waiting;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    bit          hold_req    = 1'b0;
    logic [7:0]  msg_bytes[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    superfast_byte_stream_hash_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sfh_hash_monitor u_monitor
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .error_count    (error_count),
        .hashes_waiting (hashes_waiting)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hash consumer: random stalls, plus a long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 10);
            end
        end
    end

    task send_byte(input logic [7:0] b, input logic fin);
        if (tx_idle_on && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task send_msg_bytes();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task send_random_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // Drop valid and hold until every hash is out and the pipeline has drained.
    task wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (hashes_waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_seed(input logic [HASH_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [HASH_W-1:0] seed_list[6];
        int                len;
        int                phase_end;

        seed_list[0] = 32'hFFFF_FFFF;
        seed_list[1] = 32'h0000_0000;
        seed_list[2] = $urandom;
        seed_list[3] = 32'h8000_0000;
        seed_list[4] = 32'h7FFF_FFFF;
        seed_list[5] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: every tail length, sign bit set and clear, reset seed of zero.
        msg_bytes = '{8'hFF};
        send_msg_bytes();
        msg_bytes = '{8'h00};
        send_msg_bytes();
        msg_bytes = '{8'h7F};
        send_msg_bytes();
        msg_bytes = '{8'hFF, 8'hFF};
        send_msg_bytes();
        msg_bytes = '{8'h12, 8'h34, 8'h80};
        send_msg_bytes();
        msg_bytes = '{8'hFF, 8'hFF, 8'h7F};
        send_msg_bytes();
        msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_msg_bytes();
        msg_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h81};
        send_msg_bytes();

        for (int p = 0; p < 6; p++)
        begin
            write_seed(seed_list[p]);
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2);
            if (p == 4)
                hold_req = 1'b1;
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                if (p == 4 && hold_req)
                    len = $urandom_range(1, 3);
                else if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(13, 48);
                else
                    len = $urandom_range(1, 12);
                send_random_message(len);
            end
        end

        wait_idle();
        if (error_count == 0 && hashes_waiting == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[superfast_byte_stream_hash_core.f]
hw/rtl/sfh_pkg.sv
hw/rtl/sfh_front.sv
hw/rtl/sfh_queue.sv
hw/rtl/sfh_back.sv
hw/rtl/superfast_byte_stream_hash_core.sv
hw/rtl/sfh_checker.sv
verif/sfh_hash_monitor.sv
verif/tb_superfast_byte_stream_hash_core.sv
